// File: rtl/core/prl_pkg.sv
// Shared types, codes and helpers for the prefix route lookup block.
// Used by prl_cell, prefix_route_lookup_top and the bench; depends on nothing else.
package prl_pkg;

  localparam int ADDR_W = 32;
  localparam int LEN_W  = 6;
  localparam int PORT_W = 2;
  localparam int MODE_W = 2;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  // Write or clear command broadcast from the controller to every cell.
  typedef struct packed {
    logic              ins_en;
    logic              clr;
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] hop;
    logic [PORT_W-1:0] port;
  } wr_cmd_t;

  // Lookup token handed from one cell to the next every cycle.
  typedef struct packed {
    logic              vld;
    logic              found;
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] resolve;
    logic [ADDR_W-1:0] dest;
  } lkp_tok_t;

  // Mask of the top len bits; len is already limited to 0..32.
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    prefix_mask = ~({ADDR_W{1'b1}} >> len);
  endfunction

endpackage

// File: rtl/core/prl_cell.sv
// One route slot of the lookup chain: holds prefix, length, next hop, port
// and valid bit, and passes the lookup token on each cycle. Uses prl_pkg.
module prl_cell #(
  parameter int IDX_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  prl_pkg::wr_cmd_t   wr_cmd,
  input  logic [IDX_W-1:0]   wr_idx,
  input  prl_pkg::lkp_tok_t  tok_in,
  output prl_pkg::lkp_tok_t  tok_out
);

  logic                        valid_r;
  logic [prl_pkg::ADDR_W-1:0]  prefix_r;
  logic [prl_pkg::LEN_W-1:0]   len_r;
  logic [prl_pkg::ADDR_W-1:0]  hop_r;
  logic [prl_pkg::PORT_W-1:0]  port_r;
  logic                        sel;
  logic                        match;
  logic [prl_pkg::ADDR_W-1:0]  mask;
  prl_pkg::lkp_tok_t           tok_nxt;
  prl_pkg::lkp_tok_t           tok_r;

  assign sel   = wr_cmd.ins_en && (wr_idx == IDX_W'(CELL_IDX));
  assign mask  = prl_pkg::prefix_mask(len_r);
  assign match = valid_r && ((prefix_r & mask) == (tok_in.dest & mask));

  always_comb begin
    tok_nxt = tok_in;
    // An earlier slot already won; later slots leave the token alone.
    if (!tok_in.found && match) begin
      tok_nxt.found   = 1'b1;
      tok_nxt.port    = port_r;
      tok_nxt.resolve = (hop_r != '0) ? hop_r : tok_in.dest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      if (wr_cmd.clr) begin
        valid_r <= 1'b0;
      end else if (sel) begin
        valid_r <= 1'b1;
      end
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.found   <= tok_nxt.found;
    tok_r.port    <= tok_nxt.port;
    tok_r.resolve <= tok_nxt.resolve;
    tok_r.dest    <= tok_nxt.dest;
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      prefix_r <= wr_cmd.prefix;
      len_r    <= wr_cmd.len;
      hop_r    <= wr_cmd.hop;
      port_r   <= wr_cmd.port;
    end
  end

  assign tok_out = tok_r;

endmodule

// File: rtl/core/prefix_route_lookup_top.sv
// Top level of the first-match prefix route table: controller, entry count,
// output register and the chain of prl_cell slots. Uses prl_pkg.
//
//   channel | ports                              | direction
//   in      | in_tvalid/in_tready/in_tdata/user  | command words in
//   out     | out_tvalid/out_tready/out_tdata    | one result word per command
//
// Insert, clear and the unused mode give their result in the cycle after
// acceptance. A lookup walks the chain one slot per cycle, and its result is
// registered from the token leaving the last slot, so the chain length sets when it appears.
// One command is in progress at a time; the next is taken once the output
// register is free or being emptied in the same cycle.
// Synchronous active-low reset empties the table and drops both valids.
module prefix_route_lookup_top #(
  parameter int ENTRIES = 16,
  parameter int PORTS   = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // address[31:0], prefix_length[37:32],
                                  // next_hop[69:38], port[71:70]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // hit[0], out_port[2:1],
                                  // resolve_address[34:3], table_full[35]
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } state_t;

  state_t                      state_r;
  logic                        out_vld_r;
  logic                        out_hit_r;
  logic [prl_pkg::PORT_W-1:0]  out_port_r;
  logic [prl_pkg::ADDR_W-1:0]  out_res_r;
  logic                        out_full_r;
  logic [CNT_W-1:0]            count_r;

  logic                        accept;
  prl_pkg::mode_t              in_mode;
  logic [prl_pkg::ADDR_W-1:0]  in_address;
  logic [prl_pkg::LEN_W-1:0]   in_prefix_length;
  logic [prl_pkg::ADDR_W-1:0]  in_next_hop;
  logic [prl_pkg::PORT_W-1:0]  in_port;
  logic [prl_pkg::LEN_W-1:0]   len_sat;
  logic                        port_ok;
  logic                        tbl_full;
  prl_pkg::wr_cmd_t            wr_cmd;
  prl_pkg::lkp_tok_t           tok [ENTRIES+1];

  assign in_mode          = prl_pkg::mode_t'(in_tuser);
  assign in_address       = in_tdata[31:0];
  assign in_prefix_length = in_tdata[37:32];
  assign in_next_hop      = in_tdata[69:38];
  assign in_port          = in_tdata[71:70];

  assign in_tready = (state_r == S_IDLE) && (!out_vld_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  assign len_sat  = (in_prefix_length > prl_pkg::MAX_LEN) ? prl_pkg::MAX_LEN
                                                          : in_prefix_length;
  assign port_ok  = (5'(in_port) < 5'(PORTS));
  assign tbl_full = (count_r == CNT_W'(ENTRIES));

  always_comb begin
    wr_cmd.ins_en = accept && (in_mode == prl_pkg::MODE_INSERT) && port_ok && !tbl_full;
    wr_cmd.clr    = accept && (in_mode == prl_pkg::MODE_CLEAR);
    wr_cmd.prefix = in_address;
    wr_cmd.len    = len_sat;
    wr_cmd.hop    = in_next_hop;
    wr_cmd.port   = in_port;
  end

  always_comb begin
    tok[0].vld     = accept && (in_mode == prl_pkg::MODE_LOOKUP);
    tok[0].found   = 1'b0;
    tok[0].port    = '0;
    tok[0].resolve = '0;
    tok[0].dest    = in_address;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_chain
    prl_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_entry (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_cmd  (wr_cmd),
      .wr_idx  (count_r[IDX_W-1:0]),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
      count_r   <= '0;
    end else begin
      // A command that answers at once refills the word being drained.
      if (out_vld_r && out_tready &&
          !(accept && (in_mode != prl_pkg::MODE_LOOKUP))) begin
        out_vld_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_mode == prl_pkg::MODE_LOOKUP) begin
              state_r <= S_BUSY;
            end else begin
              out_vld_r  <= 1'b1;
              out_hit_r  <= 1'b0;
              out_port_r <= '0;
              out_res_r  <= '0;
              out_full_r <= (in_mode == prl_pkg::MODE_INSERT) && port_ok && tbl_full;
            end
            if (wr_cmd.clr) begin
              count_r <= '0;
            end else if (wr_cmd.ins_en) begin
              count_r <= count_r + 1'b1;
            end
          end
        end
        S_BUSY: begin
          // The token leaving the last slot carries the first match.
          if (tok[ENTRIES].vld) begin
            state_r    <= S_IDLE;
            out_vld_r  <= 1'b1;
            out_hit_r  <= tok[ENTRIES].found;
            out_port_r <= tok[ENTRIES].port;
            out_res_r  <= tok[ENTRIES].resolve;
            out_full_r <= 1'b0;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0, out_full_r, out_res_r, out_port_r, out_hit_r};

  a_tok_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tok[ENTRIES].vld |-> (state_r == S_BUSY))
    else $error("lookup token left the chain while no lookup was pending");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRIES))
    else $error("entry count beyond table size");

  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_mode == prl_pkg::MODE_LOOKUP)) |=> (state_r == S_BUSY) && !out_vld_r)
    else $error("lookup accepted but controller not waiting on chain");

  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_full_r) |-> tbl_full)
    else $error("table_full reported while free slots remain");

  a_busy_no_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BUSY) |-> !wr_cmd.ins_en && !wr_cmd.clr)
    else $error("table written during a lookup");

endmodule

// File: bench/tb_prefix_route_lookup_top.sv
// Self-checking bench for prefix_route_lookup_top: a directed table followed by
// random route inserts, lookups, clears and unused-mode commands, checked against an in-bench route table.
// Depends on prl_pkg and prefix_route_lookup_top only.
`timescale 1ns / 100ps

module tb_prefix_route_lookup_top;

  localparam int ROUTE_SLOTS = 16;
  localparam int PORT_COUNT  = 4;
  localparam int ITEM_GOAL   = 450;
  localparam int CALM_TAIL   = 60;
  localparam int LONG_HOLD   = 300;

  typedef struct {
    prl_pkg::mode_t mode;
    logic [31:0]    addr;
    logic [5:0]     len;
    logic [31:0]    hop;
    logic [1:0]     port;
  } route_cmd_t;

  // Same bit order as out_tdata[35:0].
  typedef struct packed {
    logic        full;
    logic [31:0] resolve;
    logic [1:0]  port;
    logic        hit;
  } route_res_t;

  typedef struct {
    route_cmd_t cmd;
    bit         typed;
    route_res_t res;
  } directed_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;   // address[31:0], prefix_length[37:32],
                           // next_hop[69:38], port[71:70]
  logic [1:0]  in_tuser;   // mode[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // hit[0], out_port[2:1],
                           // resolve_address[34:3], table_full[35]

  // Route table as the bench believes it to be.
  logic [31:0] tbl_prefix [ROUTE_SLOTS];
  logic [5:0]  tbl_len    [ROUTE_SLOTS];
  logic [31:0] tbl_hop    [ROUTE_SLOTS];
  logic [1:0]  tbl_port   [ROUTE_SLOTS];
  bit          tbl_valid  [ROUTE_SLOTS];
  int          tbl_count;

  route_res_t    route_q [$];
  directed_row_t directed_rows [$];
  int            fail_count;
  int            results_seen;
  int            sent_items;
  bit            quiet;
  bit            calm;

  prefix_route_lookup_top #(
    .ENTRIES(ROUTE_SLOTS),
    .PORTS  (PORT_COUNT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [31:0] route_mask(input logic [5:0] len);
    logic [63:0] wide;
    wide = 64'hFFFF_FFFF << (32 - int'(len));
    return wide[31:0];
  endfunction

  // Applies one command to the bench table and returns the word it should produce.
  function automatic route_res_t predict_route(input route_cmd_t c);
    route_res_t  r;
    logic [5:0]  l;
    logic [31:0] m;
    r = '0;
    case (c.mode)
      prl_pkg::MODE_INSERT: begin
        l = (c.len > 6'd32) ? 6'd32 : c.len;
        if (int'(c.port) < PORT_COUNT) begin
          if (tbl_count >= ROUTE_SLOTS) begin
            r.full = 1'b1;
          end else begin
            tbl_prefix[tbl_count] = c.addr;
            tbl_len[tbl_count]    = l;
            tbl_hop[tbl_count]    = c.hop;
            tbl_port[tbl_count]   = c.port;
            tbl_valid[tbl_count]  = 1'b1;
            tbl_count++;
          end
        end
      end
      prl_pkg::MODE_LOOKUP: begin
        // First valid slot in table order wins.
        for (int i = 0; i < ROUTE_SLOTS; i++) begin
          if (tbl_valid[i] && !r.hit) begin
            m = route_mask(tbl_len[i]);
            if ((tbl_prefix[i] & m) == (c.addr & m)) begin
              r.hit     = 1'b1;
              r.port    = tbl_port[i];
              r.resolve = (tbl_hop[i] != 32'd0) ? tbl_hop[i] : c.addr;
            end
          end
        end
      end
      prl_pkg::MODE_CLEAR: begin
        for (int i = 0; i < ROUTE_SLOTS; i++) tbl_valid[i] = 1'b0;
        tbl_count = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic route_cmd_t make_cmd(input prl_pkg::mode_t mode,
                                          input logic [31:0] addr,
                                          input logic [5:0] len, input logic [31:0] hop,
                                          input logic [1:0] port);
    route_cmd_t c;
    c.mode = mode;
    c.addr = addr;
    c.len  = len;
    c.hop  = hop;
    c.port = port;
    return c;
  endfunction

  function automatic void add_row(input route_cmd_t c, input bit typed, input route_res_t res);
    directed_row_t row;
    row.cmd   = c;
    row.typed = typed;
    row.res   = res;
    directed_rows.push_back(row);
  endfunction

  function automatic route_cmd_t rand_insert();
    logic [5:0]  l;
    logic [31:0] h;
    l = ($urandom_range(0, 6) == 0) ? 6'($urandom_range(33, 63)) : 6'($urandom_range(0, 32));
    h = ($urandom_range(0, 2) == 0) ? 32'd0 : 32'($urandom);
    return make_cmd(prl_pkg::MODE_INSERT, $urandom, l, h, 2'($urandom_range(0, 3)));
  endfunction

  // Mostly aimed at a stored route, with random bits below its prefix length.
  function automatic route_cmd_t rand_lookup(input bit aimed);
    logic [31:0] dest;
    logic [31:0] m;
    int          k;
    dest = $urandom;
    if (aimed && tbl_count > 0) begin
      k    = $urandom_range(0, tbl_count - 1);
      m    = route_mask(tbl_len[k]);
      dest = (tbl_prefix[k] & m) | (dest & ~m);
    end
    return make_cmd(prl_pkg::MODE_LOOKUP, dest, 6'($urandom), $urandom, 2'($urandom));
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  task automatic send_cmd(input route_cmd_t c, input bit typed, input route_res_t typed_res);
    bit         taken;
    route_res_t guess;
    in_tvalid <= 1'b1;
    in_tuser  <= c.mode;
    in_tdata  <= {c.port, c.hop, c.len, c.addr};
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
    guess = predict_route(c);
    route_q.push_back(typed ? typed_res : guess);
    sent_items++;
  endtask

  task automatic issue(input route_cmd_t c);
    if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    send_cmd(c, 1'b0, '0);
  endtask

  task automatic build_directed();
    route_res_t zero;
    route_res_t full_res;
    zero     = '0;
    full_res = '0;
    full_res.full = 1'b1;
    add_row(make_cmd(prl_pkg::MODE_LOOKUP, 32'hC0A8_0101, 6'd0, 32'd0, 2'd0), 1'b1, zero);
    add_row(make_cmd(prl_pkg::MODE_NONE, 32'hFFFF_FFFF, 6'h3F, 32'hFFFF_FFFF, 2'd3),
            1'b1, zero);
    add_row(make_cmd(prl_pkg::MODE_CLEAR, 32'd0, 6'd0, 32'd0, 2'd0), 1'b1, zero);
    add_row(make_cmd(prl_pkg::MODE_INSERT, 32'hFFFF_FFFF, 6'd32, 32'd0, 2'd3), 1'b1, zero);
    // Oversized length saturates to a full host match.
    add_row(make_cmd(prl_pkg::MODE_INSERT, 32'd0, 6'd63, 32'hFFFF_FFFF, 2'd0), 1'b1, zero);
    add_row(make_cmd(prl_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'd0, 2'd0), 1'b0, zero);
    add_row(make_cmd(prl_pkg::MODE_LOOKUP, 32'd0, 6'd0, 32'd0, 2'd0), 1'b0, zero);
    add_row(make_cmd(prl_pkg::MODE_LOOKUP, 32'h8000_0000, 6'd0, 32'd0, 2'd0), 1'b0, zero);
    // A default route behind the host routes.
    add_row(make_cmd(prl_pkg::MODE_INSERT, 32'hA000_0000, 6'd0, 32'h0A0B_0C0D, 2'd2),
            1'b1, zero);
    add_row(make_cmd(prl_pkg::MODE_LOOKUP, 32'h8000_0000, 6'd0, 32'd0, 2'd0), 1'b0, zero);
    for (int i = 0; i < ROUTE_SLOTS - 3; i++)
      add_row(make_cmd(prl_pkg::MODE_INSERT, 32'h0A00_0000 | (i << 16), 6'd16,
                       (i % 2 == 0) ? 32'd0 : 32'hC0A8_0000 + i, 2'(i)), 1'b0, zero);
    add_row(make_cmd(prl_pkg::MODE_INSERT, 32'h1234_5678, 6'd24, 32'd1, 2'd1),
            1'b1, full_res);
    add_row(make_cmd(prl_pkg::MODE_LOOKUP, 32'h0A05_1234, 6'd0, 32'd0, 2'd0), 1'b0, zero);
  endtask

  initial begin : stimulus
    int         pick;
    int         burst;
    bit         drained;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = prl_pkg::MODE_NONE;
    fail_count   = 0;
    sent_items   = 0;
    quiet        = 1'b0;
    calm         = 1'b0;
    drained      = 1'b0;
    tbl_count    = 0;
    for (int i = 0; i < ROUTE_SLOTS; i++) tbl_valid[i] = 1'b0;
    build_directed();
    wait (rst_n);
    @(posedge clk);
    foreach (directed_rows[i])
      send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].res);

    while (sent_items < ITEM_GOAL) begin
      quiet = (sent_items >= ITEM_GOAL - CALM_TAIL);
      if ($urandom_range(0, 11) == 0) calm = ~calm;
      if (!drained && sent_items >= 220) begin
        // Let the block run dry before going on.
        drained = 1'b1;
        in_tvalid <= 1'b0;
        do @(posedge clk); while (route_q.size() != 0);
      end
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        issue(make_cmd(prl_pkg::MODE_CLEAR, $urandom, 6'($urandom), $urandom,
                       2'($urandom)));
        burst = $urandom_range(1, 20);
        repeat (burst) issue(rand_insert());
      end else if (pick < 13) begin
        issue(rand_lookup(1'b1));
      end else if (pick < 16) begin
        issue(rand_insert());
      end else if (pick < 18) begin
        issue(rand_lookup(1'b0));
      end else if (pick == 18) begin
        issue(make_cmd(prl_pkg::MODE_NONE, $urandom, 6'($urandom), $urandom,
                       2'($urandom)));
      end else begin
        issue(make_cmd(prl_pkg::MODE_CLEAR, $urandom, 6'($urandom), $urandom,
                       2'($urandom)));
      end
    end
    in_tvalid <= 1'b0;

    while (route_q.size() != 0) @(posedge clk);
    repeat (2 * (ROUTE_SLOTS + 1)) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold that backs the block up.
  initial begin : result_sink
    bit held;
    out_tready = 1'b0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && results_seen >= 150) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_tready <= 1'b1;
      end else if (rst_n && !quiet && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : result_check
    route_res_t got;
    route_res_t want;
    results_seen = 0;
    forever begin
      @(negedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got = out_tdata[35:0];
        if (route_q.size() == 0) begin
          report_mismatch("unexpected word", {28'd0, got[35:32]}, 32'd0);
        end else begin
          want = route_q.pop_front();
          if (got.hit !== want.hit)
            report_mismatch("hit", 32'(got.hit), 32'(want.hit));
          if (got.port !== want.port)
            report_mismatch("out_port", 32'(got.port), 32'(want.port));
          if (got.resolve !== want.resolve)
            report_mismatch("resolve_address", got.resolve, want.resolve);
          if (got.full !== want.full)
            report_mismatch("table_full", 32'(got.full), 32'(want.full));
        end
        results_seen++;
      end
    end
  end

endmodule
